[src/lmcs_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helpers for the LED matrix column scanner.
// No dependencies; used by the top, the scan core and the bench.
package lmcs_pkg;

   // Default geometry of the matrix and of the PWM cycle
   localparam int COLUMNS_DEFAULT       = 22;
   localparam int PWM_LAST_SLOT_DEFAULT = 5;

   // Fixed field widths
   localparam int COLUMN_FIELD_W = 5;
   localparam int ROW_W          = 8;
   localparam int BRIGHTNESS_W   = 3;
   localparam int REQ_TDATA_W    = 16;

   // Register reset value and row mask
   localparam logic [BRIGHTNESS_W-1:0] BRIGHTNESS_RESET = 3'd5;
   localparam logic [ROW_W-1:0]        ROW_KEEP_MASK    = 8'h80;

   // Item kinds carried in tuser
   typedef enum logic {
      KIND_TICK  = 1'b0,
      KIND_WRITE = 1'b1
   } kind_type;

   // One request beat, unpacked from the stream ports
   typedef struct packed {
      kind_type                  kind;
      logic [COLUMN_FIELD_W-1:0] column;
      logic [ROW_W-1:0]          pixels;
      logic                      mirror_switch;
   } req_beat_type;

   // Reverse bits 0..6, bit 7 of the result is zero
   function automatic logic [ROW_W-1:0] reverse_low7(input logic [ROW_W-1:0] value);
      logic [ROW_W-1:0] result;
      result = '0;
      for (int b = 0; b < 7; b++) begin
         result[6 - b] = value[b];
      end
      return result;
   endfunction

endpackage

[src/led_matrix_column_scanner.sv]
`timescale 1ns / 1ps
// LED matrix column scanner: one beat in per cycle while req_tready is high, one
// result beat out per beat in. A refresh tick steps the PWM slot; at the last slot
// one column is lit (active low) with its frame buffer byte, mirrored on request;
// at the slot equal to brightness the display is blanked. A write beat stores one
// column byte. Each accepted beat yields exactly one result beat holding the drive
// lines after it, registered in the output buffer; the scan logic takes a new beat
// every cycle that req_tready is high and a two-entry output buffer keeps req_tready
// high for one beat while a result waits. The frame buffer is cleared at reset.
// The user must write brightness through csr_ while the block is idle; not enforced.
module led_matrix_column_scanner #(
   parameter int COLUMNS       = lmcs_pkg::COLUMNS_DEFAULT,
   parameter int PWM_LAST_SLOT = lmcs_pkg::PWM_LAST_SLOT_DEFAULT,
   localparam int RSP_W        = COLUMNS + lmcs_pkg::ROW_W + 1,
   localparam int RSP_TDATA_W  = ((RSP_W + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [4:0] column, [12:5] pixels, [13] mirror_switch, [15:14] zero
   input  logic [lmcs_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] kind
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [COLUMNS-1:0] column_drive_n, then row_data (8), frame_done, zero fill
   output logic [RSP_TDATA_W-1:0]            rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lmcs_pkg::BRIGHTNESS_W-1:0] csr_data
);

   lmcs_pkg::req_beat_type     beat;
   logic                       beat_accept;
   logic [COLUMNS-1:0]         next_drive_n;
   logic [lmcs_pkg::ROW_W-1:0] next_row;
   logic                       next_done;
   logic [RSP_W-1:0]           rsp_result;

   // Unpack the request beat
   always_comb begin
      beat.kind          = lmcs_pkg::kind_type'(req_tuser);
      beat.column        = req_tdata[4:0];
      beat.pixels        = req_tdata[12:5];
      beat.mirror_switch = req_tdata[13];
   end

   assign beat_accept = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;

   lmcs_scan_core #(
      .COLUMNS       (COLUMNS),
      .PWM_LAST_SLOT (PWM_LAST_SLOT)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .beat_accept  (beat_accept),
      .beat         (beat),
      .csr_write    (csr_valid && csr_ready),
      .csr_value    (csr_data),
      .next_drive_n (next_drive_n),
      .next_row     (next_row),
      .next_done    (next_done)
   );

   lmcs_skid #(
      .DATA_W (RSP_W)
   ) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (beat_accept),
      .in_ready  (req_tready),
      .in_data   ({next_done, next_row, next_drive_n}),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   assign rsp_tdata = RSP_TDATA_W'(rsp_result);

endmodule

[src/lmcs_scan_core.sv]
`timescale 1ns / 1ps
// Scan state, frame buffer and brightness register of the column scanner.
// Depends on lmcs_pkg; produces the drive lines after each accepted beat.
module lmcs_scan_core #(
   parameter int COLUMNS       = lmcs_pkg::COLUMNS_DEFAULT,
   parameter int PWM_LAST_SLOT = lmcs_pkg::PWM_LAST_SLOT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              beat_accept,
   input  lmcs_pkg::req_beat_type            beat,
   input  logic                              csr_write,
   input  logic [lmcs_pkg::BRIGHTNESS_W-1:0] csr_value,
   output logic [COLUMNS-1:0]                next_drive_n,
   output logic [lmcs_pkg::ROW_W-1:0]        next_row,
   output logic                              next_done
);

   localparam int SCAN_W = $clog2(COLUMNS);
   localparam int SLOT_W = $clog2(PWM_LAST_SLOT + 1);
   localparam int CMP_W  = (SLOT_W > lmcs_pkg::BRIGHTNESS_W) ? SLOT_W : lmcs_pkg::BRIGHTNESS_W;
   localparam int COLCMP_W = lmcs_pkg::COLUMN_FIELD_W + 1;

   logic [lmcs_pkg::ROW_W-1:0]        fb_ff [COLUMNS];
   logic [SCAN_W-1:0]                 scan_ff, scan_in;
   logic [SLOT_W-1:0]                 slot_ff, slot_in;
   logic                              mirrored_ff, mirrored_in;
   logic                              seen_ff, seen_in;
   logic [COLUMNS-1:0]                col_ff, col_in;
   logic [lmcs_pkg::ROW_W-1:0]        row_ff, row_in;
   logic [lmcs_pkg::BRIGHTNESS_W-1:0] bright_ff;

   logic                              is_tick;
   logic                              write_ok;
   logic [SCAN_W-1:0]                 lit;
   logic [lmcs_pkg::ROW_W-1:0]        px;

   assign is_tick  = beat_accept && (beat.kind == lmcs_pkg::KIND_TICK);
   assign write_ok = beat_accept && (beat.kind == lmcs_pkg::KIND_WRITE) &&
                     ({1'b0, beat.column} < COLCMP_W'(COLUMNS));
   assign px       = fb_ff[scan_ff];

   // Work out the scan state after a tick
   always_comb begin
      scan_in     = scan_ff;
      slot_in     = slot_ff;
      mirrored_in = mirrored_ff;
      seen_in     = seen_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      lit         = mirrored_ff ? scan_ff : SCAN_W'(COLUMNS - 1) - scan_ff;
      if (is_tick) begin
         if (slot_ff != SLOT_W'(PWM_LAST_SLOT)) begin
            // early slot: blank when the duty cycle runs out
            if (CMP_W'(slot_ff) == CMP_W'(bright_ff)) begin
               col_in = '1;
               row_in = row_ff & lmcs_pkg::ROW_KEEP_MASK;
            end
            slot_in = slot_ff + SLOT_W'(1);
         end else begin
            // last slot: light the next column
            slot_in = '0;
            for (int i = 0; i < COLUMNS; i++) begin
               col_in[i] = (SCAN_W'(i) != lit);
            end
            row_in = mirrored_ff ? lmcs_pkg::reverse_low7(px) : px;
            if (scan_ff == SCAN_W'(COLUMNS - 1)) begin
               scan_in     = '0;
               mirrored_in = beat.mirror_switch;
               seen_in     = 1'b1;
            end else begin
               scan_in = scan_ff + SCAN_W'(1);
            end
         end
      end
   end

   // Hold scan state and brightness
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff     <= '0;
         slot_ff     <= '0;
         mirrored_ff <= 1'b0;
         seen_ff     <= 1'b0;
         col_ff      <= '1;
         row_ff      <= '0;
         bright_ff   <= lmcs_pkg::BRIGHTNESS_RESET;
      end else begin
         scan_ff     <= scan_in;
         slot_ff     <= slot_in;
         mirrored_ff <= mirrored_in;
         seen_ff     <= seen_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         if (csr_write) begin
            bright_ff <= csr_value;
         end
      end
   end

   // Store column bytes; the buffer is cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COLUMNS; i++) begin
            fb_ff[i] <= '0;
         end
      end else if (write_ok) begin
         fb_ff[SCAN_W'(beat.column)] <= beat.pixels;
      end
   end

   assign next_drive_n = col_in;
   assign next_row     = row_in;
   assign next_done    = seen_in;

   a_one_column_lit : assert property (@(posedge clock) disable iff (reset)
      $countones(~col_ff) <= 1)
      else $error("more than one column driven low");

   a_slot_range : assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(PWM_LAST_SLOT))
      else $error("pwm slot out of range");

   a_scan_range : assert property (@(posedge clock) disable iff (reset)
      scan_ff <= SCAN_W'(COLUMNS - 1))
      else $error("scan column out of range");

endmodule

[src/lmcs_skid.sv]
`timescale 1ns / 1ps
// Two-entry output buffer: result register plus skid register.
// Depends on nothing; ready toward the core comes straight from a flop.
module lmcs_skid #(
   parameter int DATA_W = 31
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);

   logic              main_valid_ff;
   logic [DATA_W-1:0] main_ff;
   logic              skid_valid_ff;
   logic [DATA_W-1:0] skid_ff;
   logic              push;
   logic              main_free;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign main_free = !main_valid_ff || out_ready;

   // Advance the result register, park a beat in the skid when stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (main_free) begin
         main_ff <= skid_valid_ff ? skid_ff : in_data;
      end else if (push) begin
         skid_ff <= in_data;
      end
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   a_skid_behind_main : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid holds a beat while the result register is empty");

   a_skid_drains : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_ready |=> main_valid_ff && !skid_valid_ff)
      else $error("skid beat not moved forward");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for the LED matrix column scanner: random stream traffic
// with idle and stall phases, checked beat by beat against an in-bench scan model.
// Depends on lmcs_pkg and led_matrix_column_scanner.
module testbench;

   import lmcs_pkg::*;

   localparam int COLUMNS     = COLUMNS_DEFAULT;
   localparam int SLOT_LAST   = PWM_LAST_SLOT_DEFAULT;
   localparam int RSP_W       = COLUMNS + ROW_W + 1;
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8;
   localparam int ITEMS_PER_PHASE = 183;

   // Drive lines the scanner should show after one beat
   typedef struct packed {
      logic [COLUMNS-1:0] drive_n;
      logic [ROW_W-1:0]   row;
      logic               done;
   } scan_result_type;

   // Scan model plus the queue of drive-line states still owed by the block
   class scan_scoreboard;
      logic [ROW_W-1:0]        frame_bytes [COLUMNS];
      logic [COLUMN_FIELD_W:0] scan_col;
      logic [2:0]              slot;
      logic                    mirrored;
      logic                    frame_seen;
      logic [COLUMNS-1:0]      drive_n;
      logic [ROW_W-1:0]        row;
      logic [BRIGHTNESS_W-1:0] brightness;
      scan_result_type         owed [$];
      int                      errors;

      function new();
         foreach (frame_bytes[i]) frame_bytes[i] = '0;
         scan_col   = '0;
         slot       = '0;
         mirrored   = 1'b0;
         frame_seen = 1'b0;
         drive_n    = '1;
         row        = '0;
         brightness = BRIGHTNESS_RESET;
         errors     = 0;
      endfunction

      function void set_brightness(logic [BRIGHTNESS_W-1:0] value);
         brightness = value;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // All columns off, keep only the top row bit
      function void blank_lines();
         drive_n = '1;
         row     = row & ROW_KEEP_MASK;
      endfunction

      // Step the model by one accepted request beat and queue its result
      function void note_beat(req_beat_type b);
         scan_result_type  r;
         logic [ROW_W-1:0] px;
         int               lit;
         if (b.kind == KIND_WRITE) begin
            // drop writes past the last column
            if (b.column < COLUMNS) frame_bytes[b.column] = b.pixels;
         end else if (slot != SLOT_LAST) begin
            if (slot == brightness) blank_lines();
            slot = slot + 1'b1;
         end else begin
            slot = '0;
            blank_lines();
            px = frame_bytes[scan_col];
            if (mirrored) begin
               lit = scan_col;
               row = '0;
               for (int i = 0; i < 7; i++) row[6 - i] = px[i];
            end else begin
               lit = COLUMNS - 1 - scan_col;
               row = px;
            end
            drive_n[lit] = 1'b0;
            scan_col = scan_col + 1'b1;
            // frame wrap: sample the mirror switch
            if (scan_col == COLUMNS) begin
               scan_col   = '0;
               mirrored   = b.mirror_switch;
               frame_seen = 1'b1;
            end
         end
         r.drive_n = drive_n;
         r.row     = row;
         r.done    = frame_seen;
         owed.push_back(r);
      endfunction

      // Compare one result beat with the oldest owed state, field by field
      function void check_beat(logic [RSP_TDATA_W-1:0] data);
         scan_result_type exp_r;
         logic [COLUMNS-1:0] got_drive;
         logic [ROW_W-1:0]   got_row;
         logic               got_done;
         got_drive = data[COLUMNS-1:0];
         got_row   = data[COLUMNS +: ROW_W];
         got_done  = data[COLUMNS + ROW_W];
         if (owed.size() == 0) begin
            $display("%0t: unexpected result beat, actual %h", $time, data);
            errors++;
            return;
         end
         exp_r = owed.pop_front();
         if (got_drive !== exp_r.drive_n) begin
            $display("%0t: column_drive_n mismatch, expected %h actual %h",
                     $time, exp_r.drive_n, got_drive);
            errors++;
         end
         if (got_row !== exp_r.row) begin
            $display("%0t: row_data mismatch, expected %h actual %h",
                     $time, exp_r.row, got_row);
            errors++;
         end
         if (got_done !== exp_r.done) begin
            $display("%0t: frame_done mismatch, expected %h actual %h",
                     $time, exp_r.done, got_done);
            errors++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata = '0;
   logic                     req_tuser = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [BRIGHTNESS_W-1:0]  csr_data = '0;

   int             idle_pct  = 0;
   int             stall_pct = 0;
   scan_scoreboard scan_sb   = new();

   led_matrix_column_scanner u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // Stall the result side at the current rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Watch both streams: model accepted requests, check accepted results
   always @(posedge clock) begin
      req_beat_type b;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            b.kind          = kind_type'(req_tuser);
            b.column        = req_tdata[4:0];
            b.pixels        = req_tdata[12:5];
            b.mirror_switch = req_tdata[13];
            scan_sb.note_beat(b);
         end
         if (rsp_tvalid && rsp_tready) scan_sb.check_beat(rsp_tdata);
      end
   end

   // Send one request beat after a random gap, hold until accepted
   task automatic send_beat(req_beat_type b);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(0, 99) < idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= b.kind;
      req_tdata  <= {2'b00, b.mirror_switch, b.pixels, b.column};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_fields(kind_type k, int col, int px, int mirror);
      req_beat_type b;
      b.kind          = k;
      b.column        = col[COLUMN_FIELD_W-1:0];
      b.pixels        = px[ROW_W-1:0];
      b.mirror_switch = mirror[0];
      send_beat(b);
   endtask

   // Stop sending and wait for every owed result, then let the pipe settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (scan_sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_brightness(logic [BRIGHTNESS_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      scan_sb.set_brightness(value);
   endtask

   // Mostly ticks so frames wrap; writes land mostly in range
   task automatic run_random(int count);
      req_beat_type b;
      for (int i = 0; i < count; i++) begin
         b.kind          = ($urandom_range(0, 99) < 82) ? KIND_TICK : KIND_WRITE;
         b.column        = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(22, 31))
                                                       : 5'($urandom_range(0, 21));
         b.pixels        = 8'($urandom);
         b.mirror_switch = 1'($urandom_range(0, 1));
         send_beat(b);
         // hold off once until the block has caught up
         if (i == count / 2 && idle_pct != 0 && stall_pct == 0) drain();
      end
   endtask

   initial begin
      logic [BRIGHTNESS_W-1:0] phase_brightness [4];
      int                      phase_idle [4];
      int                      phase_stall [4];
      phase_brightness = '{3'd0, 3'd3, 3'd7, 3'd5};
      phase_idle       = '{0, 58, 0, 36};
      phase_stall      = '{0, 0, 58, 36};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: edge columns, top row bit, ignored writes, first column lit
      send_fields(KIND_WRITE, 0, 8'h81, 1);
      send_fields(KIND_WRITE, 21, 8'hFF, 0);
      send_fields(KIND_WRITE, 1, 8'h00, 1);
      send_fields(KIND_WRITE, 2, 8'h7F, 0);
      send_fields(KIND_WRITE, 22, 8'h55, 0);
      send_fields(KIND_WRITE, 31, 8'hAA, 1);
      send_fields(KIND_WRITE, 16, 8'h5A, 0);
      for (int i = 0; i < 18; i++) send_fields(KIND_TICK, 31 - i, 8'hFF - i, i % 2);
      drain();

      // Random phases, one brightness, idle and stall pattern each
      for (int p = 0; p < 4; p++) begin
         write_brightness(phase_brightness[p]);
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         run_random(ITEMS_PER_PHASE);
         drain();
      end

      if (scan_sb.errors == 0 && scan_sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

[led_matrix_column_scanner.f]
src/lmcs_pkg.sv
src/lmcs_scan_core.sv
src/lmcs_skid.sv
src/led_matrix_column_scanner.sv
tb/sv/testbench.sv
